// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl of the point transform block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define PT2D_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define PT2D_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pt2d_pkg.sv -----
// constants, cordic angle table and operation codes of the point transform block
`default_nettype none

package pt2d_pkg;

  localparam int FUNC_W   = 2;
  localparam int ANGLE_W  = 16;
  localparam int SCALE_W  = 16;

  // cordic datapath, q2.30 for cos/sin and a 32-bit binary angle
  localparam int CW       = 32;
  localparam int ATAN_LEN = 24;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 32'sh26DD3B6A;

  // fraction bits dropped after each product
  localparam int ROT_FRAC   = 30;
  localparam int SCALE_FRAC = 8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TRANSLATE = 2'd0,
    FUNC_ROTATE    = 2'd1,
    FUNC_SCALE     = 2'd2,
    FUNC_PASS      = 2'd3
  } func_e;

  typedef logic [CW-1:0] atan_tab_t [0:ATAN_LEN-1];

  // atan(2^-i) as a 32-bit binary angle
  localparam atan_tab_t ATAN_TAB = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

endpackage

`default_nettype wire

// ----- rtl/pt2d_in_if.sv -----
// input channel: vertex, pivot, offset, angle, scale and operation select
`default_nettype none

interface pt2d_in_if #(
  parameter int COORD_WIDTH = 32
) ();

  logic                                      valid;
  logic                                      ready;
  logic        [pt2d_pkg::FUNC_W-1:0]        func;
  logic signed [COORD_WIDTH-1:0]             point_x;
  logic signed [COORD_WIDTH-1:0]             point_y;
  logic signed [COORD_WIDTH-1:0]             pivot_x;
  logic signed [COORD_WIDTH-1:0]             pivot_y;
  logic signed [COORD_WIDTH-1:0]             offset_x;
  logic signed [COORD_WIDTH-1:0]             offset_y;
  logic        [pt2d_pkg::ANGLE_W-1:0]       angle;
  logic signed [pt2d_pkg::SCALE_W-1:0]       scale;

  modport source (
    output valid, func, point_x, point_y, pivot_x, pivot_y, offset_x, offset_y, angle, scale,
    input  ready
  );

  modport sink (
    input  valid, func, point_x, point_y, pivot_x, pivot_y, offset_x, offset_y, angle, scale,
    output ready
  );

endinterface

`default_nettype wire

// ----- rtl/pt2d_out_if.sv -----
// output channel: transformed vertex and clip flag
`default_nettype none

interface pt2d_out_if #(
  parameter int COORD_WIDTH = 32
) ();

  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] result_x;
  logic signed [COORD_WIDTH-1:0] result_y;
  logic                          saturated;

  modport source (
    output valid, result_x, result_y, saturated,
    input  ready
  );

  modport sink (
    input  valid, result_x, result_y, saturated,
    output ready
  );

endinterface

`default_nettype wire

// ----- rtl/point_transform_2d.sv -----
// point transform top: translate, rotate, scale or pass one q16.16 vertex per beat
//
//   channel  dir   interface           payload
//   in_i     sink  pt2d_in_if.sink     func, point, pivot, offset, angle, scale
//   out_o    src   pt2d_out_if.source  result_x, result_y, saturated
//
// one beat per cycle while out_o is not stalled; the pipe is an entry stage, the chain
// of cordic stages, then multiply, combine, round and saturate stages
// every stage holds a valid bit; a stage takes a new beat when it is empty or the
// stage after it moves, so bubbles close up while the output is stalled
// reset clears the valid bits only
`default_nettype none
`include "assert_macros.svh"

module point_transform_2d #(
  parameter int COORD_WIDTH   = 32,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  pt2d_in_if.sink     in_i,
  pt2d_out_if.source  out_o
);

  localparam int CW     = pt2d_pkg::CW;
  localparam int DW     = COORD_WIDTH + 1;
  localparam int LW     = DW / 2;
  localparam int HW     = DW - LW;
  localparam int LOW    = LW + 1 + CW;
  localparam int HIW    = HW + CW;
  localparam int PW     = DW + CW;
  localparam int KW     = DW + pt2d_pkg::SCALE_W;
  localparam int RW     = PW + 2;
  localparam int SW     = COORD_WIDTH + 11;
  localparam int NS     = CORDIC_STAGES + 5;
  localparam int ST_MUL = CORDIC_STAGES + 1;
  localparam int ST_SUM = CORDIC_STAGES + 2;
  localparam int ST_RND = CORDIC_STAGES + 3;
  localparam int ST_OUT = CORDIC_STAGES + 4;

  localparam logic signed [RW-1:0] ROT_HALF   = RW'(1) <<< (pt2d_pkg::ROT_FRAC - 1);
  localparam logic signed [RW-1:0] SCALE_HALF = RW'(1) <<< (pt2d_pkg::SCALE_FRAC - 1);
  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  typedef struct packed {
    pt2d_pkg::func_e                     func;
    logic                                flip;
    logic [pt2d_pkg::SCALE_W-1:0]        scale;
    logic [COORD_WIDTH-1:0]              base_x;
    logic [COORD_WIDTH-1:0]              base_y;
    logic [DW-1:0]                       d_x;
    logic [DW-1:0]                       d_y;
  } item_t;

  // handshake chain
  logic [NS-1:0] vld_q;
  logic [NS-1:0] rdy;

  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = out_o.ready | ~(&vld_q[NS-1:k]);
  end

  assign in_i.ready = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_i.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // entry stage: operand setup and angle fold
  item_t                  in_itm;
  logic [CW-1:0]          ang_full;
  logic                   ang_flip;
  pt2d_pkg::func_e        in_func;

  assign in_func  = pt2d_pkg::func_e'(in_i.func);
  assign ang_full = {in_i.angle, {(CW-pt2d_pkg::ANGLE_W){1'b0}}};
  assign ang_flip = ang_full[CW-1] ^ ang_full[CW-2];

  always_comb begin
    in_itm.func  = in_func;
    in_itm.flip  = ang_flip;
    in_itm.scale = in_i.scale;
    unique case (in_func)
      pt2d_pkg::FUNC_ROTATE, pt2d_pkg::FUNC_SCALE: begin
        in_itm.base_x = in_i.pivot_x;
        in_itm.base_y = in_i.pivot_y;
        in_itm.d_x    = {in_i.point_x[COORD_WIDTH-1], in_i.point_x}
                      - {in_i.pivot_x[COORD_WIDTH-1], in_i.pivot_x};
        in_itm.d_y    = {in_i.point_y[COORD_WIDTH-1], in_i.point_y}
                      - {in_i.pivot_y[COORD_WIDTH-1], in_i.pivot_y};
      end
      pt2d_pkg::FUNC_TRANSLATE: begin
        in_itm.base_x = in_i.point_x;
        in_itm.base_y = in_i.point_y;
        in_itm.d_x    = {in_i.offset_x[COORD_WIDTH-1], in_i.offset_x};
        in_itm.d_y    = {in_i.offset_y[COORD_WIDTH-1], in_i.offset_y};
      end
      pt2d_pkg::FUNC_PASS: begin
        in_itm.base_x = in_i.point_x;
        in_itm.base_y = in_i.point_y;
        in_itm.d_x    = '0;
        in_itm.d_y    = '0;
      end
    endcase
  end

  item_t                  itm_q [0:CORDIC_STAGES];
  logic signed [CW-1:0]   cx_q  [0:CORDIC_STAGES];
  logic signed [CW-1:0]   cy_q  [0:CORDIC_STAGES];
  logic [CW-1:0]          cz_q  [0:CORDIC_STAGES-1];

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      itm_q[0] <= in_itm;
      cx_q[0]  <= pt2d_pkg::CORDIC_GAIN;
      cy_q[0]  <= '0;
      cz_q[0]  <= {ang_full[CW-1] ^ ang_flip, ang_full[CW-2:0]};
    end
  end

  // cordic rotation stages
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] x_d;
    logic signed [CW-1:0] y_d;

    assign xs  = cx_q[i] >>> i;
    assign ys  = cy_q[i] >>> i;
    assign x_d = cz_q[i][CW-1] ? cx_q[i] + ys : cx_q[i] - ys;
    assign y_d = cz_q[i][CW-1] ? cy_q[i] - xs : cy_q[i] + xs;

    always_ff @(posedge clk_i) begin
      if (rdy[i+1]) begin
        itm_q[i+1] <= itm_q[i];
        cx_q[i+1]  <= x_d;
        cy_q[i+1]  <= y_d;
      end
    end

    if (i < CORDIC_STAGES - 1) begin : g_angle
      logic [CW-1:0] z_d;

      assign z_d = cz_q[i][CW-1] ? cz_q[i] + pt2d_pkg::ATAN_TAB[i]
                                 : cz_q[i] - pt2d_pkg::ATAN_TAB[i];

      always_ff @(posedge clk_i) begin
        if (rdy[i+1]) begin
          cz_q[i+1] <= z_d;
        end
      end
    end
  end

  // multiply stage: split coordinate deltas into halves, and scale the deltas
  item_t                  mul_itm_q;
  logic signed [LOW-1:0]  lo_xc_q, lo_ys_q, lo_xs_q, lo_yc_q;
  logic signed [HIW-1:0]  hi_xc_q, hi_ys_q, hi_xs_q, hi_yc_q;
  logic signed [KW-1:0]   kx_q, ky_q;
  item_t                  mi;

  assign mi = itm_q[CORDIC_STAGES];

  always_ff @(posedge clk_i) begin
    if (rdy[ST_MUL]) begin
      mul_itm_q <= mi;
      lo_xc_q   <= $signed({1'b0, mi.d_x[LW-1:0]}) * cx_q[CORDIC_STAGES];
      lo_ys_q   <= $signed({1'b0, mi.d_y[LW-1:0]}) * cy_q[CORDIC_STAGES];
      lo_xs_q   <= $signed({1'b0, mi.d_x[LW-1:0]}) * cy_q[CORDIC_STAGES];
      lo_yc_q   <= $signed({1'b0, mi.d_y[LW-1:0]}) * cx_q[CORDIC_STAGES];
      hi_xc_q   <= $signed(mi.d_x[DW-1:LW]) * cx_q[CORDIC_STAGES];
      hi_ys_q   <= $signed(mi.d_y[DW-1:LW]) * cy_q[CORDIC_STAGES];
      hi_xs_q   <= $signed(mi.d_x[DW-1:LW]) * cy_q[CORDIC_STAGES];
      hi_yc_q   <= $signed(mi.d_y[DW-1:LW]) * cx_q[CORDIC_STAGES];
      kx_q      <= $signed(mi.d_x) * $signed(mi.scale);
      ky_q      <= $signed(mi.d_y) * $signed(mi.scale);
    end
  end

  // combine stage: join the partial products
  item_t                 sum_itm_q;
  logic signed [PW-1:0]  p_xc_q, p_ys_q, p_xs_q, p_yc_q;
  logic signed [KW-1:0]  skx_q, sky_q;

  always_ff @(posedge clk_i) begin
    if (rdy[ST_SUM]) begin
      sum_itm_q <= mul_itm_q;
      p_xc_q    <= {hi_xc_q, {LW{1'b0}}} + {{(PW-LOW){lo_xc_q[LOW-1]}}, lo_xc_q};
      p_ys_q    <= {hi_ys_q, {LW{1'b0}}} + {{(PW-LOW){lo_ys_q[LOW-1]}}, lo_ys_q};
      p_xs_q    <= {hi_xs_q, {LW{1'b0}}} + {{(PW-LOW){lo_xs_q[LOW-1]}}, lo_xs_q};
      p_yc_q    <= {hi_yc_q, {LW{1'b0}}} + {{(PW-LOW){lo_yc_q[LOW-1]}}, lo_yc_q};
      skx_q     <= kx_q;
      sky_q     <= ky_q;
    end
  end

  // round stage: rotation sums with quadrant sign, or scaled deltas
  item_t                 rnd_itm_q;
  logic signed [RW-1:0]  r_x_q, r_y_q;
  logic signed [RW-1:0]  r_x_d, r_y_d;
  logic signed [RW-1:0]  e_xc, e_ys, e_xs, e_yc, e_kx, e_ky;

  assign e_xc = {{(RW-PW){p_xc_q[PW-1]}}, p_xc_q};
  assign e_ys = {{(RW-PW){p_ys_q[PW-1]}}, p_ys_q};
  assign e_xs = {{(RW-PW){p_xs_q[PW-1]}}, p_xs_q};
  assign e_yc = {{(RW-PW){p_yc_q[PW-1]}}, p_yc_q};
  assign e_kx = {{(RW-KW){skx_q[KW-1]}}, skx_q};
  assign e_ky = {{(RW-KW){sky_q[KW-1]}}, sky_q};

  always_comb begin
    unique case (sum_itm_q.func)
      pt2d_pkg::FUNC_ROTATE: begin
        if (sum_itm_q.flip) begin
          r_x_d = e_ys - e_xc + ROT_HALF;
          r_y_d = ROT_HALF - e_xs - e_yc;
        end else begin
          r_x_d = e_xc - e_ys + ROT_HALF;
          r_y_d = e_xs + e_yc + ROT_HALF;
        end
      end
      pt2d_pkg::FUNC_SCALE: begin
        r_x_d = e_kx + SCALE_HALF;
        r_y_d = e_ky + SCALE_HALF;
      end
      pt2d_pkg::FUNC_TRANSLATE, pt2d_pkg::FUNC_PASS: begin
        r_x_d = '0;
        r_y_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_RND]) begin
      rnd_itm_q <= sum_itm_q;
      r_x_q     <= r_x_d;
      r_y_q     <= r_y_d;
    end
  end

  // output stage: add base and clip
  function automatic logic [COORD_WIDTH:0] clip(input logic [SW-1:0] v);
    logic [SW-COORD_WIDTH:0] top;
    top = v[SW-1:COORD_WIDTH-1];
    if ((&top) || !(|top)) begin
      clip = {1'b0, v[COORD_WIDTH-1:0]};
    end else if (v[SW-1]) begin
      clip = {1'b1, COORD_MIN};
    end else begin
      clip = {1'b1, COORD_MAX};
    end
  endfunction

  logic signed [RW-1:0]      sh_x, sh_y;
  logic [SW-1:0]             term_x, term_y;
  logic [SW-1:0]             sum_x, sum_y;
  logic [COORD_WIDTH:0]      clip_x, clip_y;

  always_comb begin
    unique case (rnd_itm_q.func)
      pt2d_pkg::FUNC_ROTATE: begin
        sh_x = r_x_q >>> pt2d_pkg::ROT_FRAC;
        sh_y = r_y_q >>> pt2d_pkg::ROT_FRAC;
        term_x = sh_x[SW-1:0];
        term_y = sh_y[SW-1:0];
      end
      pt2d_pkg::FUNC_SCALE: begin
        sh_x = r_x_q >>> pt2d_pkg::SCALE_FRAC;
        sh_y = r_y_q >>> pt2d_pkg::SCALE_FRAC;
        term_x = sh_x[SW-1:0];
        term_y = sh_y[SW-1:0];
      end
      pt2d_pkg::FUNC_TRANSLATE, pt2d_pkg::FUNC_PASS: begin
        sh_x = r_x_q;
        sh_y = r_y_q;
        term_x = {{(SW-DW){rnd_itm_q.d_x[DW-1]}}, rnd_itm_q.d_x};
        term_y = {{(SW-DW){rnd_itm_q.d_y[DW-1]}}, rnd_itm_q.d_y};
      end
    endcase
  end

  assign sum_x  = {{(SW-COORD_WIDTH){rnd_itm_q.base_x[COORD_WIDTH-1]}}, rnd_itm_q.base_x}
                + term_x;
  assign sum_y  = {{(SW-COORD_WIDTH){rnd_itm_q.base_y[COORD_WIDTH-1]}}, rnd_itm_q.base_y}
                + term_y;
  assign clip_x = clip(sum_x);
  assign clip_y = clip(sum_y);

  logic signed [COORD_WIDTH-1:0] res_x_q, res_y_q;
  logic                          sat_q;
  pt2d_pkg::func_e               res_func_q;

  always_ff @(posedge clk_i) begin
    if (rdy[ST_OUT]) begin
      res_x_q    <= clip_x[COORD_WIDTH-1:0];
      res_y_q    <= clip_y[COORD_WIDTH-1:0];
      sat_q      <= clip_x[COORD_WIDTH] | clip_y[COORD_WIDTH];
      res_func_q <= rnd_itm_q.func;
    end
  end

  assign out_o.valid     = vld_q[ST_OUT];
  assign out_o.result_x  = res_x_q;
  assign out_o.result_y  = res_y_q;
  assign out_o.saturated = sat_q;

  // checks
  `PT2D_ASSERT_NXT(a_entry_loads, clk_i, rst_ni, in_i.valid && in_i.ready, vld_q[0],
                   "accepted beat missing from entry stage")
  `PT2D_ASSERT_IMP(a_full_blocks, clk_i, rst_ni, !out_o.ready && (&vld_q), !in_i.ready,
                   "input taken while every stage is full")
  `PT2D_ASSERT_IMP(a_sat_bound, clk_i, rst_ni, out_o.valid && out_o.saturated,
                   (res_x_q == COORD_MAX || res_x_q == COORD_MIN ||
                    res_y_q == COORD_MAX || res_y_q == COORD_MIN),
                   "clip flag without a coordinate at a bound")
  `PT2D_ASSERT_IMP(a_pass_clean, clk_i, rst_ni,
                   out_o.valid && (res_func_q == pt2d_pkg::FUNC_PASS), !out_o.saturated,
                   "pass-through beat flagged as clipped")

endmodule

`default_nettype wire

// ----- tb/pt2d_result_check.sv -----
`timescale 1ns / 1ps
// result checker for the point transform: predicts every input beat and compares in order
module pt2d_result_check #(
  parameter int COORD_WIDTH   = 32,
  parameter int CORDIC_STAGES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  pt2d_in_if   in_mon_i,
  pt2d_out_if  out_mon_i,
  output int   fail_count_o,
  output int   pending_o
);

  typedef logic signed [95:0] wide_t;
  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   sat;
  } xformed_t;

  localparam wide_t ROT_HALF   = wide_t'(1) <<< (pt2d_pkg::ROT_FRAC - 1);
  localparam wide_t SCALE_HALF = wide_t'(1) <<< (pt2d_pkg::SCALE_FRAC - 1);
  localparam wide_t COORD_HI   = (wide_t'(1) <<< (COORD_WIDTH - 1)) - wide_t'(1);
  localparam wide_t COORD_LO   = -COORD_HI - wide_t'(1);

  xformed_t expected_points[$];
  int       mismatches;

  function automatic void cordic_cos_sin(input logic [pt2d_pkg::ANGLE_W-1:0] ang,
                                         output longint c, output longint s);
    logic [31:0] a;
    logic        flip;
    longint      x, y, z, xs, ys;
    a    = {ang, 16'h0000};
    flip = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
    if (flip) a = a + 32'h8000_0000;
    x = longint'(pt2d_pkg::CORDIC_GAIN);
    y = 0;
    z = longint'(signed'(a));
    for (int i = 0; i < CORDIC_STAGES && i < pt2d_pkg::ATAN_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(pt2d_pkg::ATAN_TAB[i]);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(pt2d_pkg::ATAN_TAB[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic coord_t clip_coord(input wide_t w, inout logic sat);
    if (w > COORD_HI) begin
      sat = 1'b1;
      return coord_t'(COORD_HI);
    end
    if (w < COORD_LO) begin
      sat = 1'b1;
      return coord_t'(COORD_LO);
    end
    return coord_t'(w);
  endfunction

  function automatic xformed_t transform_point(input pt2d_pkg::func_e f,
                                               input coord_t px, py, cx, cy, ox, oy,
                                               input logic [pt2d_pkg::ANGLE_W-1:0] ang,
                                               input logic signed [pt2d_pkg::SCALE_W-1:0] k);
    wide_t    wx, wy, dx, dy;
    longint   c, s;
    xformed_t r;
    dx = wide_t'(px) - wide_t'(cx);
    dy = wide_t'(py) - wide_t'(cy);
    case (f)
      pt2d_pkg::FUNC_TRANSLATE: begin
        wx = wide_t'(px) + wide_t'(ox);
        wy = wide_t'(py) + wide_t'(oy);
      end
      pt2d_pkg::FUNC_ROTATE: begin
        cordic_cos_sin(ang, c, s);
        // y uses the original dx, not the rotated x
        wx = dx * wide_t'(c) - dy * wide_t'(s) + ROT_HALF;
        wy = dx * wide_t'(s) + dy * wide_t'(c) + ROT_HALF;
        wx = wide_t'(cx) + (wx >>> pt2d_pkg::ROT_FRAC);
        wy = wide_t'(cy) + (wy >>> pt2d_pkg::ROT_FRAC);
      end
      pt2d_pkg::FUNC_SCALE: begin
        wx = wide_t'(cx) + ((dx * wide_t'(k) + SCALE_HALF) >>> pt2d_pkg::SCALE_FRAC);
        wy = wide_t'(cy) + ((dy * wide_t'(k) + SCALE_HALF) >>> pt2d_pkg::SCALE_FRAC);
      end
      default: begin
        wx = wide_t'(px);
        wy = wide_t'(py);
      end
    endcase
    r.sat = 1'b0;
    r.x   = clip_coord(wx, r.sat);
    r.y   = clip_coord(wy, r.sat);
    return r;
  endfunction

  always @(posedge clk_i) begin
    xformed_t want;
    if (rst_ni) begin
      if (in_mon_i.valid && in_mon_i.ready) begin
        expected_points.push_back(transform_point(pt2d_pkg::func_e'(in_mon_i.func),
          in_mon_i.point_x, in_mon_i.point_y, in_mon_i.pivot_x, in_mon_i.pivot_y,
          in_mon_i.offset_x, in_mon_i.offset_y, in_mon_i.angle, in_mon_i.scale));
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (expected_points.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result beat with nothing expected: x=%h y=%h sat=%b", $realtime,
                     out_mon_i.result_x, out_mon_i.result_y, out_mon_i.saturated);
        end else begin
          want = expected_points.pop_front();
          if (out_mon_i.result_x !== want.x || out_mon_i.result_y !== want.y ||
              out_mon_i.saturated !== want.sat) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: expected x=%h y=%h sat=%b, got x=%h y=%h sat=%b",
                       $realtime, want.x, want.y, want.sat, out_mon_i.result_x,
                       out_mon_i.result_y, out_mon_i.saturated);
          end
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_points.size();
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// testbench top for the point transform: clock, reset, beat stimulus, stalls and verdict
module tb_top;

  localparam int COORD_WIDTH   = 32;
  localparam int CORDIC_STAGES = 16;
  localparam int LATENCY       = CORDIC_STAGES + 5;
  localparam int RANDOM_BEATS  = 800;
  localparam int STEADY_FROM   = 700;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_START    = 500;
  localparam int HOLD_CYCLES   = 300;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  localparam coord_t C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam coord_t ONE   = coord_t'(32'sh0001_0000);

  typedef struct {
    pt2d_pkg::func_e                      func;
    coord_t                               px, py, cx, cy, ox, oy;
    logic [pt2d_pkg::ANGLE_W-1:0]         angle;
    logic signed [pt2d_pkg::SCALE_W-1:0]  scale;
  } vertex_req_t;

  logic clk_i;
  logic rst_ni;
  bit   steady;
  int   fail_count;
  int   pending;

  pt2d_in_if  #(.COORD_WIDTH(COORD_WIDTH)) in_bus ();
  pt2d_out_if #(.COORD_WIDTH(COORD_WIDTH)) out_bus ();

  point_transform_2d #(
    .COORD_WIDTH  (COORD_WIDTH),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  pt2d_result_check #(
    .COORD_WIDTH  (COORD_WIDTH),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon_i    (in_bus),
    .out_mon_i   (out_bus),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic offer_vertex(input vertex_req_t r);
    in_bus.valid    <= 1'b1;
    in_bus.func     <= r.func;
    in_bus.point_x  <= r.px;
    in_bus.point_y  <= r.py;
    in_bus.pivot_x  <= r.cx;
    in_bus.pivot_y  <= r.cy;
    in_bus.offset_x <= r.ox;
    in_bus.offset_y <= r.oy;
    in_bus.angle    <= r.angle;
    in_bus.scale    <= r.scale;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
  endtask

  task automatic offer_fields(input pt2d_pkg::func_e f, input coord_t px, py, cx, cy, ox, oy,
                              input logic [pt2d_pkg::ANGLE_W-1:0] ang,
                              input logic signed [pt2d_pkg::SCALE_W-1:0] k);
    vertex_req_t r;
    r.func = f;
    r.px = px; r.py = py; r.cx = cx; r.cy = cy; r.ox = ox; r.oy = oy;
    r.angle = ang;
    r.scale = k;
    offer_vertex(r);
  endtask

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 7))
      0:       return C_MAX;
      1:       return C_MIN;
      2, 3:    return coord_t'({$urandom(), $urandom()});
      default: return coord_t'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
    endcase
  endfunction

  function automatic vertex_req_t pick_vertex();
    vertex_req_t r;
    int          sel;
    sel = $urandom_range(0, 9);
    if (sel < 3)      r.func = pt2d_pkg::FUNC_TRANSLATE;
    else if (sel < 6) r.func = pt2d_pkg::FUNC_ROTATE;
    else if (sel < 9) r.func = pt2d_pkg::FUNC_SCALE;
    else              r.func = pt2d_pkg::FUNC_PASS;
    r.px = pick_coord();
    r.py = pick_coord();
    r.cx = pick_coord();
    r.cy = pick_coord();
    r.ox = pick_coord();
    r.oy = pick_coord();
    if ($urandom_range(0, 3) == 0)
      r.angle = {2'($urandom_range(0, 3)), 14'h0000} + 16'($urandom_range(0, 2)) - 16'd1;
    else
      r.angle = 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 7))
      0:       r.scale = 16'sh0100;
      1:       r.scale = 16'sh7FFF;
      2:       r.scale = 16'sh8000;
      3, 4:    r.scale = 16'(int'($urandom_range(0, 1024)) - 512);
      default: r.scale = 16'($urandom_range(0, 65535));
    endcase
    return r;
  endfunction

  // sink side: random stall bursts, one long hold-off, none near the end
  initial begin : result_sink
    int stall_left;
    int cyc;
    bit busy_mode;
    stall_left = 0;
    cyc        = 0;
    busy_mode  = 1'b0;
    out_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc % 150 == 0) busy_mode = ($urandom_range(0, 2) == 0);
      if (steady) begin
        out_bus.ready <= 1'b1;
      end else if (cyc == HOLD_START) begin
        stall_left = HOLD_CYCLES - 1;
        out_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (!busy_mode && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_top: errors");
    $finish;
  end

  initial begin : stimulus
    logic [pt2d_pkg::ANGLE_W-1:0] dir_angles [10];
    bit                           busy_mode;
    dir_angles = '{16'h0000, 16'h2000, 16'h3FFF, 16'h4000, 16'h4001,
                   16'h8000, 16'hBFFF, 16'hC000, 16'hC001, 16'hFFFF};
    busy_mode = 1'b0;
    steady    = 1'b0;
    rst_ni          <= 1'b0;
    in_bus.valid    <= 1'b0;
    in_bus.func     <= pt2d_pkg::FUNC_TRANSLATE;
    in_bus.point_x  <= '0;
    in_bus.point_y  <= '0;
    in_bus.pivot_x  <= '0;
    in_bus.pivot_y  <= '0;
    in_bus.offset_x <= '0;
    in_bus.offset_y <= '0;
    in_bus.angle    <= '0;
    in_bus.scale    <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // translate corners, with and without clipping
    offer_fields(pt2d_pkg::FUNC_TRANSLATE, 0, 0, 0, 0, 0, 0, 16'h0000, 16'sh0000);
    offer_fields(pt2d_pkg::FUNC_TRANSLATE, C_MAX, C_MIN, 0, 0, ONE, -ONE,
                 16'hFFFF, 16'sh7FFF);
    offer_fields(pt2d_pkg::FUNC_TRANSLATE, C_MAX, C_MIN, 0, 0, C_MIN, C_MAX,
                 16'h0000, 16'sh8000);
    offer_fields(pt2d_pkg::FUNC_TRANSLATE, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN,
                 16'h0000, 0);
    offer_fields(pt2d_pkg::FUNC_TRANSLATE, -1, 1, 0, 0, 1, -1, 16'h0000, 16'sh0000);
    // rotate unit vector through the quadrant folds
    foreach (dir_angles[i])
      offer_fields(pt2d_pkg::FUNC_ROTATE, ONE, 0, 0, 0, 0, 0, dir_angles[i], 16'sh0000);
    offer_fields(pt2d_pkg::FUNC_ROTATE, C_MAX, C_MAX, C_MIN, C_MIN, 0, 0,
                 16'h2000, 16'sh0000);
    offer_fields(pt2d_pkg::FUNC_ROTATE, C_MIN, C_MAX, C_MAX, C_MIN, 0, 0,
                 16'h6000, 16'sh0000);
    offer_fields(pt2d_pkg::FUNC_ROTATE, ONE * 3 + 5, -ONE + 7, ONE * 2, -ONE * 4, 0, 0,
                 16'h1234, 0);
    // scale: identity, rounding ties, clipping both ways, collapse to pivot
    offer_fields(pt2d_pkg::FUNC_SCALE, ONE, -ONE, 0, 0, 0, 0, 16'h0000, 16'sh0100);
    offer_fields(pt2d_pkg::FUNC_SCALE, 1, -1, 0, 0, 0, 0, 16'h0000, 16'sh0080);
    offer_fields(pt2d_pkg::FUNC_SCALE, C_MAX, C_MIN, C_MIN, C_MAX, 0, 0,
                 16'h0000, 16'sh7FFF);
    offer_fields(pt2d_pkg::FUNC_SCALE, C_MAX, C_MIN, C_MIN, C_MAX, 0, 0,
                 16'h0000, 16'sh8000);
    offer_fields(pt2d_pkg::FUNC_SCALE, 32'sh1234_5678, -32'sh0abc_def0, ONE, ONE, 0, 0,
                 0, 16'sh0000);
    // unused selector passes the vertex through
    offer_fields(pt2d_pkg::FUNC_PASS, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX,
                 16'hFFFF, 16'sh8000);
    offer_fields(pt2d_pkg::FUNC_PASS, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN,
                 16'h4000, 16'sh7FFF);

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 50 == 0) busy_mode = ($urandom_range(0, 2) == 0);
      if (n == STEADY_FROM) steady = 1'b1;
      if (!steady && !busy_mode && $urandom_range(0, 3) == 0) begin
        in_bus.valid <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
      offer_vertex(pick_vertex());
    end
    in_bus.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
